// ----- sv/vxoh_pkg.sv -----
// ----------------------------------------------------------------------------
// vxoh_pkg: shared definitions for the VXLAN outer header parser
// Ethertypes, protocol numbers, verdict codes and the result record.
// ----------------------------------------------------------------------------
`default_nettype none

package vxoh_pkg;

  // Default UDP destination port of VXLAN traffic.
  localparam logic [15:0] VXLAN_PORT_DEFAULT = 16'd4789;

  // Ethertypes and the IP protocol number of UDP.
  localparam logic [15:0] ETYPE_VLAN = 16'h8100;
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;

  // Header sizes and field offsets in bytes.
  localparam logic [6:0] L2_PLAIN_LEN    = 7'd14;
  localparam logic [6:0] L2_TAGGED_LEN   = 7'd18;
  localparam logic [6:0] IPV4_LEN        = 7'd20;
  localparam logic [6:0] IPV6_LEN        = 7'd40;
  localparam logic [6:0] IPV4_PROTO_OFS  = 7'd9;
  localparam logic [6:0] IPV6_PROTO_OFS  = 7'd6;
  localparam logic [6:0] UDP_DPORT_OFS   = 7'd2;
  localparam logic [6:0] UDP_VXLAN_LEN   = 7'd16;
  localparam logic [6:0] HDR_LEN_MIN     = 7'd50;
  localparam logic [6:0] HDR_LEN_MAX     = 7'd74;

  // Tunnel kind that this parser handles.
  localparam logic [1:0] KIND_VXLAN = 2'd0;

  // Verdict codes.
  typedef enum logic [2:0] {
    VERDICT_DECAP   = 3'd0,
    VERDICT_NOT_UDP = 3'd1,
    VERDICT_PORT    = 3'd2,
    VERDICT_KIND    = 3'd3,
    VERDICT_TRUNC   = 3'd4
  } verdict_t;

  // One verdict as it travels to the output.
  typedef struct packed {
    logic       strip;
    logic [6:0] header_length;
    verdict_t   code;
  } result_t;

endpackage

`default_nettype wire

// ----- sv/vxlan_outer_header_parser.sv -----
// ----------------------------------------------------------------------------
// vxlan_outer_header_parser: per-packet VXLAN outer header verdict
// Parses Ethernet (one optional VLAN tag), IPv4 or IPv6 and the UDP
// destination port from a byte stream and gives one strip verdict per packet.
// ----------------------------------------------------------------------------
//
//   Channel | Handshake             | Payload
//   --------+-----------------------+--------------------------------------
//   in_     | in_valid / in_stall   | data_byte, first/last_of_packet, hint
//   out_    | out_valid / out_stall | strip, header_length, verdict_code
//   cfg_    | cfg_valid / cfg_ready | vxlan_udp_port
//
// One byte is accepted per cycle while in_stall is low. A verdict is computed
// from the byte in the input register and registered in the result register.
// A two-entry result queue (result register plus skid entry) lets bytes flow
// while a verdict waits; in_stall rises only when both entries are full.
// Reset is synchronous and active low; no clearing pass is needed.
`default_nettype none

module vxlan_outer_header_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Byte stream input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_first_of_packet,
  input  wire logic        in_last_of_packet,
  input  wire logic        in_tunnel_hint,
  input  wire logic [1:0]  in_tunnel_kind,
  // Verdict output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_strip,
  output logic [6:0]       out_header_length,
  output logic [2:0]       out_verdict_code,
  // Configuration write
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_vxlan_udp_port
);

  // Configuration register.
  logic [15:0] udp_port_r;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_first_r;
  logic       s1_last_r;
  logic       s1_hint_r;
  logic [1:0] s1_kind_r;

  // Parser state.
  logic [6:0] offset_r,   offset_nxt;
  logic [7:0] etype_hi_r, etype_hi_nxt;
  logic [7:0] port_hi_r,  port_hi_nxt;
  logic       vlan_r,     vlan_nxt;
  logic       l3_known_r, l3_known_nxt;
  logic       l3_v6_r,    l3_v6_nxt;
  logic       sent_r,     sent_nxt;
  logic       hint_r,     hint_nxt;

  // Result queue.
  logic                   main_valid_r;
  logic                   skid_valid_r;
  vxoh_pkg::result_t      main_r;
  vxoh_pkg::result_t      skid_r;

  logic                   s1_fire;
  logic                   out_pop;
  logic                   emit;
  vxoh_pkg::result_t      res;

  // Working values of the byte in the input register.
  logic        sent_cur;
  logic [6:0]  off_cur;
  logic [6:0]  l2_len;
  logic [6:0]  l3_len;
  logic        vlan_cur;
  logic        l3_known_cur;
  logic        l3_v6_cur;
  logic        hint_cur;
  logic [15:0] etype;
  logic [15:0] dport;
  logic [6:0]  proto_at;
  logic [6:0]  port_at;

  // Handshakes: the input register holds while the queue is full.
  assign s1_fire  = s1_valid_r && !skid_valid_r;
  assign in_stall = s1_valid_r && skid_valid_r;
  assign out_pop  = main_valid_r && !out_stall;
  assign cfg_ready = 1'b1;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      udp_port_r <= vxoh_pkg::VXLAN_PORT_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      udp_port_r <= cfg_vxlan_udp_port;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r  <= in_data_byte;
      s1_first_r <= in_first_of_packet;
      s1_last_r  <= in_last_of_packet;
      s1_hint_r  <= in_tunnel_hint;
      s1_kind_r  <= in_tunnel_kind;
    end
  end

  // Parse one byte: a first byte restarts the packet state.
  always_comb begin
    sent_cur     = s1_first_r ? 1'b0 : sent_r;
    off_cur      = s1_first_r ? 7'd0 : offset_r;
    vlan_cur     = s1_first_r ? 1'b0 : vlan_r;
    l3_known_cur = s1_first_r ? 1'b0 : l3_known_r;
    l3_v6_cur    = s1_first_r ? 1'b0 : l3_v6_r;
    hint_cur     = s1_first_r ? s1_hint_r : hint_r;

    l2_len   = vlan_cur ? vxoh_pkg::L2_TAGGED_LEN : vxoh_pkg::L2_PLAIN_LEN;
    l3_len   = l3_v6_cur ? vxoh_pkg::IPV6_LEN : vxoh_pkg::IPV4_LEN;
    proto_at = l2_len + (l3_v6_cur ? vxoh_pkg::IPV6_PROTO_OFS : vxoh_pkg::IPV4_PROTO_OFS);
    port_at  = l2_len + l3_len + vxoh_pkg::UDP_DPORT_OFS;
    etype    = {etype_hi_r, s1_byte_r};
    dport    = {port_hi_r, s1_byte_r};

    offset_nxt   = off_cur + 7'd1;
    etype_hi_nxt = etype_hi_r;
    port_hi_nxt  = port_hi_r;
    vlan_nxt     = vlan_cur;
    l3_known_nxt = l3_known_cur;
    l3_v6_nxt    = l3_v6_cur;
    hint_nxt     = hint_cur;

    emit              = 1'b0;
    res.strip         = 1'b0;
    res.header_length = 7'd0;
    res.code          = vxoh_pkg::VERDICT_TRUNC;

    if (s1_first_r && (s1_kind_r != vxoh_pkg::KIND_VXLAN)) begin
      // Tunnel kinds other than VXLAN are rejected at once.
      emit     = 1'b1;
      res.code = vxoh_pkg::VERDICT_KIND;
    end else if (!sent_cur) begin
      // Ethertype, high byte then low byte.
      if (off_cur == l2_len - 7'd2) begin
        etype_hi_nxt = s1_byte_r;
      end
      if (off_cur == l2_len - 7'd1) begin
        if (!vlan_cur && (etype == vxoh_pkg::ETYPE_VLAN)) begin
          vlan_nxt = 1'b1;
        end else if (etype == vxoh_pkg::ETYPE_IPV4) begin
          l3_known_nxt = 1'b1;
          l3_v6_nxt    = 1'b0;
        end else if (etype == vxoh_pkg::ETYPE_IPV6) begin
          l3_known_nxt = 1'b1;
          l3_v6_nxt    = 1'b1;
        end else begin
          emit     = 1'b1;
          res.code = vxoh_pkg::VERDICT_NOT_UDP;
        end
      end

      // Protocol byte and UDP destination port.
      if (!emit && l3_known_cur) begin
        if ((off_cur == proto_at) && (s1_byte_r != vxoh_pkg::PROTO_UDP)) begin
          emit     = 1'b1;
          res.code = vxoh_pkg::VERDICT_NOT_UDP;
        end
        if (off_cur == port_at) begin
          port_hi_nxt = s1_byte_r;
        end
        if (!emit && (off_cur == port_at + 7'd1)) begin
          emit = 1'b1;
          if ((dport == udp_port_r) || hint_cur) begin
            res.strip         = 1'b1;
            res.header_length = l2_len + l3_len + vxoh_pkg::UDP_VXLAN_LEN;
            res.code          = vxoh_pkg::VERDICT_DECAP;
          end else begin
            res.code = vxoh_pkg::VERDICT_PORT;
          end
        end
      end

      // Packet ended before a decision.
      if (!emit && s1_last_r) begin
        emit     = 1'b1;
        res.code = vxoh_pkg::VERDICT_TRUNC;
      end
    end

    sent_nxt = sent_cur || emit;
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r   <= 7'd0;
      etype_hi_r <= 8'd0;
      port_hi_r  <= 8'd0;
      vlan_r     <= 1'b0;
      l3_known_r <= 1'b0;
      l3_v6_r    <= 1'b0;
      sent_r     <= 1'b1;
      hint_r     <= 1'b0;
    end else if (s1_fire) begin
      offset_r   <= offset_nxt;
      etype_hi_r <= etype_hi_nxt;
      port_hi_r  <= port_hi_nxt;
      vlan_r     <= vlan_nxt;
      l3_known_r <= l3_known_nxt;
      l3_v6_r    <= l3_v6_nxt;
      sent_r     <= sent_nxt;
      hint_r     <= hint_nxt;
    end
  end

  // Result queue: result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_pop) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= s1_fire && emit;
      end
    end else if (!main_valid_r) begin
      main_valid_r <= s1_fire && emit;
    end else if (s1_fire && emit) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_pop && skid_valid_r) begin
      main_r <= skid_r;
    end else if (out_pop || !main_valid_r) begin
      main_r <= res;
    end
    if (main_valid_r && !out_pop && !skid_valid_r) begin
      skid_r <= res;
    end
  end

  assign out_valid         = main_valid_r;
  assign out_strip         = main_r.strip;
  assign out_header_length = main_r.header_length;
  assign out_verdict_code  = main_r.code;

`ifndef SYNTHESIS
  // The skid entry is only ever occupied behind a full result register.
  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry valid with empty result register");

  // Strip is given exactly for the decapsulated verdict.
  a_strip_code: assert property (@(posedge clk) disable iff (!rst_n)
    main_valid_r |-> (main_r.strip == (main_r.code == vxoh_pkg::VERDICT_DECAP)))
    else $error("strip flag disagrees with verdict code");

  // A stripped header spans Ethernet, IP, UDP and VXLAN.
  a_strip_len: assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && main_r.strip) |->
      (main_r.header_length >= vxoh_pkg::HDR_LEN_MIN &&
       main_r.header_length <= vxoh_pkg::HDR_LEN_MAX))
    else $error("header length out of range");

  // No stripping means no length.
  a_nostrip_len: assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && !main_r.strip) |-> (main_r.header_length == 7'd0))
    else $error("nonzero header length without strip");

  // Once a verdict is out, the packet stays closed until its next first byte.
  a_sent_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (sent_r && !(s1_fire && s1_first_r)) |=> sent_r)
    else $error("verdict flag cleared without a packet start");
`endif

endmodule

`default_nettype wire

// ----- sim/vxlan_outer_header_parser_test.sv -----
// ----------------------------------------------------------------------------
// vxlan_outer_header_parser_test: verdict checking bench for the outer parser
// Streams Ethernet/VLAN/IPv4/IPv6/UDP packets byte by byte with random gaps and
// output stalls, predicts each per-packet verdict and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module vxlan_outer_header_parser_test;

  // Outer layer-3 choice of a generated packet.
  localparam int L3_V4    = 0;
  localparam int L3_V6    = 1;
  localparam int L3_OTHER = 2;

  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int PHASE_BYTES   = 150;

  // One byte request on the input channel.
  typedef struct {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       hint;
    logic [1:0] kind;
  } byte_req_t;

  // Shape of one generated packet.
  typedef struct {
    logic [1:0]  kind;
    logic        hint;
    int          tags;
    int          l3;
    logic [7:0]  proto;
    logic [15:0] dport;
    int          len;
    bit          open_end;
  } pkt_spec_t;

  // Tracks the parse state of the packet in flight and the verdicts still owed.
  class verdict_scoreboard;
    logic [15:0]       udp_port;
    logic [6:0]        offset;
    logic [15:0]       etype;
    logic [6:0]        l2_len;
    logic [6:0]        l3_len;
    logic [15:0]       dport;
    bit                done;
    logic              hint;
    vxoh_pkg::result_t pending_verdicts[$];
    int                errors;
    int                verdicts;

    function new();
      udp_port = vxoh_pkg::VXLAN_PORT_DEFAULT;
      offset   = '0;
      etype    = '0;
      l2_len   = vxoh_pkg::L2_PLAIN_LEN;
      l3_len   = '0;
      dport    = '0;
      done     = 1'b1;
      hint     = 1'b0;
      errors   = 0;
      verdicts = 0;
    endfunction

    function void owe_verdict(logic strip, logic [6:0] hlen, vxoh_pkg::verdict_t code);
      vxoh_pkg::result_t r;
      r.strip         = strip;
      r.header_length = strip ? hlen : 7'd0;
      r.code          = code;
      pending_verdicts.push_back(r);
      done = 1'b1;
    endfunction

    // Advances the parse by one accepted byte request.
    function void parse_byte(byte_req_t q);
      logic [6:0] off;
      logic [6:0] proto_at;
      logic [6:0] port_at;
      if (q.first) begin
        offset = '0;
        etype  = '0;
        l2_len = vxoh_pkg::L2_PLAIN_LEN;
        l3_len = '0;
        dport  = '0;
        done   = 1'b0;
        hint   = q.hint;
        if (q.kind != vxoh_pkg::KIND_VXLAN) begin
          owe_verdict(1'b0, 7'd0, vxoh_pkg::VERDICT_KIND);
          return;
        end
      end
      if (done) return;
      off = offset;

      // Ethertype, with one VLAN tag allowed before it.
      if (off == l2_len - 7'd2 || off == l2_len - 7'd1) etype = {etype[7:0], q.data};
      if (off == l2_len - 7'd1) begin
        if (l2_len == vxoh_pkg::L2_PLAIN_LEN && etype == vxoh_pkg::ETYPE_VLAN) begin
          l2_len = vxoh_pkg::L2_TAGGED_LEN;
        end else if (etype == vxoh_pkg::ETYPE_IPV4) begin
          l3_len = vxoh_pkg::IPV4_LEN;
        end else if (etype == vxoh_pkg::ETYPE_IPV6) begin
          l3_len = vxoh_pkg::IPV6_LEN;
        end else begin
          owe_verdict(1'b0, 7'd0, vxoh_pkg::VERDICT_NOT_UDP);
          return;
        end
      end

      // Protocol byte and UDP destination port.
      if (l3_len != 0) begin
        proto_at = l2_len + ((l3_len == vxoh_pkg::IPV4_LEN) ? vxoh_pkg::IPV4_PROTO_OFS
                                                             : vxoh_pkg::IPV6_PROTO_OFS);
        port_at  = l2_len + l3_len + vxoh_pkg::UDP_DPORT_OFS;
        if (off == proto_at && q.data != vxoh_pkg::PROTO_UDP) begin
          owe_verdict(1'b0, 7'd0, vxoh_pkg::VERDICT_NOT_UDP);
          return;
        end
        if (off == port_at || off == port_at + 7'd1) dport = {dport[7:0], q.data};
        if (off == port_at + 7'd1) begin
          if (dport == udp_port || hint)
            owe_verdict(1'b1, l2_len + l3_len + vxoh_pkg::UDP_VXLAN_LEN,
                        vxoh_pkg::VERDICT_DECAP);
          else
            owe_verdict(1'b0, 7'd0, vxoh_pkg::VERDICT_PORT);
          return;
        end
      end

      if (q.last) begin
        owe_verdict(1'b0, 7'd0, vxoh_pkg::VERDICT_TRUNC);
        return;
      end
      offset = offset + 7'd1;
    endfunction

    // Compares one accepted verdict with the oldest one owed.
    function void check_verdict(logic strip, logic [6:0] hlen, logic [2:0] code);
      vxoh_pkg::result_t e;
      verdicts++;
      if (pending_verdicts.size() == 0) begin
        $error("verdict with none pending: strip %b length %0d code %0d", strip, hlen, code);
        errors++;
        return;
      end
      e = pending_verdicts.pop_front();
      if (strip !== e.strip) begin
        $error("strip: expected %b, actual %b", e.strip, strip);
        errors++;
      end
      if (hlen !== e.header_length) begin
        $error("header_length: expected %0d, actual %0d", e.header_length, hlen);
        errors++;
      end
      if (code !== e.code) begin
        $error("verdict_code: expected %0d, actual %0d", e.code, code);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_first_of_packet = 1'b0;
  logic        in_last_of_packet = 1'b0;
  logic        in_tunnel_hint = 1'b0;
  logic [1:0]  in_tunnel_kind = 2'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_strip;
  logic [6:0]  out_header_length;
  logic [2:0]  out_verdict_code;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_vxlan_udp_port = 16'd0;

  verdict_scoreboard sb;
  bit steady = 1'b0;
  bit hold_off_req = 1'b0;
  int bytes_sent = 0;

  vxlan_outer_header_parser dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_data_byte       (in_data_byte),
    .in_first_of_packet (in_first_of_packet),
    .in_last_of_packet  (in_last_of_packet),
    .in_tunnel_hint     (in_tunnel_hint),
    .in_tunnel_kind     (in_tunnel_kind),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_strip          (out_strip),
    .out_header_length  (out_header_length),
    .out_verdict_code   (out_verdict_code),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_vxlan_udp_port (cfg_vxlan_udp_port)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Gap length: mostly none, a few short, rarely long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Input side: note every accepted request.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      byte_req_t q;
      q.data  = in_data_byte;
      q.first = in_first_of_packet;
      q.last  = in_last_of_packet;
      q.hint  = in_tunnel_hint;
      q.kind  = in_tunnel_kind;
      sb.parse_byte(q);
    end
  end

  // Output side: check every accepted verdict.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_verdict(out_strip, out_header_length, out_verdict_code);
  end

  // Receiver stalls, with one long hold-off when requested.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
        out_stall <= 1'b0;
      end else if (stall_left > 0 && !steady) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = 0;
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
      end
    end
  end

  // Offers one request and returns at the edge that accepts it.
  task automatic drive_request(input byte_req_t q);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_data_byte       <= q.data;
    in_first_of_packet <= q.first;
    in_last_of_packet  <= q.last;
    in_tunnel_hint     <= q.hint;
    in_tunnel_kind     <= q.kind;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering and waits until every owed verdict has come out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_udp_port(input logic [15:0] port);
    drain();
    cfg_valid          <= 1'b1;
    cfg_vxlan_udp_port <= port;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.udp_port = port;
  endtask

  // Number of bytes up to and including the deciding byte, for VXLAN kind and UDP protocol.
  function automatic int decision_len(pkt_spec_t s);
    int l2;
    if (s.tags == 2) return 18;
    l2 = (s.tags != 0) ? 18 : 14;
    if (s.l3 == L3_OTHER) return l2;
    return l2 + ((s.l3 == L3_V4) ? 20 : 40) + 4;
  endfunction

  function automatic pkt_spec_t make_spec(logic [1:0] kind, logic hint, int tags, int l3,
                                          logic [7:0] proto, logic [15:0] dport, int len,
                                          bit open_end);
    pkt_spec_t s;
    s.kind     = kind;
    s.hint     = hint;
    s.tags     = tags;
    s.l3       = l3;
    s.proto    = proto;
    s.dport    = dport;
    s.len      = len;
    s.open_end = open_end;
    return s;
  endfunction

  // Mostly well-formed VXLAN candidates, with truncated, aborted and foreign ones mixed in.
  function automatic pkt_spec_t random_packet();
    pkt_spec_t s;
    int r;
    int dec;
    s.kind     = ($urandom_range(0, 99) < 85) ? vxoh_pkg::KIND_VXLAN
                                               : 2'($urandom_range(1, 3));
    s.hint     = ($urandom_range(0, 4) == 0);
    r          = $urandom_range(0, 9);
    s.tags     = (r < 6) ? 0 : (r < 9) ? 1 : 2;
    r          = $urandom_range(0, 19);
    s.l3       = (r < 9) ? L3_V4 : (r < 17) ? L3_V6 : L3_OTHER;
    s.proto    = ($urandom_range(0, 99) < 85) ? vxoh_pkg::PROTO_UDP
                                               : 8'($urandom_range(0, 255));
    s.dport    = ($urandom_range(0, 9) < 7) ? sb.udp_port : 16'($urandom_range(0, 65535));
    s.open_end = 1'b0;
    dec        = decision_len(s);
    r          = $urandom_range(0, 99);
    if (r < 55) begin
      s.len = dec + $urandom_range(0, 24);
    end else begin
      s.len = $urandom_range(1, dec);
      s.open_end = (r >= 85);
    end
    return s;
  endfunction

  // Builds the packet bytes and streams them.
  task automatic send_packet(input pkt_spec_t s);
    logic [7:0]  pkt[];
    logic [15:0] etype;
    int          l2;
    int          l3len;
    int          i;
    byte_req_t   q;
    pkt = new[96];
    for (i = 0; i < 96; i++) pkt[i] = 8'($urandom_range(0, 255));
    if (s.l3 == L3_V4) begin
      etype = vxoh_pkg::ETYPE_IPV4;
    end else if (s.l3 == L3_V6) begin
      etype = vxoh_pkg::ETYPE_IPV6;
    end else begin
      etype = 16'($urandom_range(0, 65535));
      if (etype == vxoh_pkg::ETYPE_IPV4 || etype == vxoh_pkg::ETYPE_IPV6 ||
          etype == vxoh_pkg::ETYPE_VLAN) etype ^= 16'h0001;
    end
    if (s.tags == 0) begin
      {pkt[12], pkt[13]} = etype;
    end else begin
      {pkt[12], pkt[13]} = vxoh_pkg::ETYPE_VLAN;
      {pkt[16], pkt[17]} = (s.tags == 2) ? vxoh_pkg::ETYPE_VLAN : etype;
    end
    l2 = (s.tags != 0) ? 18 : 14;
    if (s.tags != 2 && s.l3 != L3_OTHER) begin
      l3len = (s.l3 == L3_V4) ? 20 : 40;
      pkt[l2 + ((s.l3 == L3_V4) ? 9 : 6)] = s.proto;
      {pkt[l2 + l3len + 2], pkt[l2 + l3len + 3]} = s.dport;
    end
    for (i = 0; i < s.len; i++) begin
      q.data  = pkt[i];
      q.first = (i == 0);
      q.last  = (i == s.len - 1) && !s.open_end;
      q.hint  = (i == 0) ? s.hint : 1'($urandom_range(0, 1));
      q.kind  = (i == 0) ? s.kind : 2'($urandom_range(0, 3));
      drive_request(q);
      bytes_sent++;
    end
  endtask

  // Bytes with no packet open; the block drops them.
  task automatic send_stray_bytes();
    byte_req_t q;
    int n;
    n = $urandom_range(1, 4);
    repeat (n) begin
      q.data  = 8'($urandom_range(0, 255));
      q.first = 1'b0;
      q.last  = 1'($urandom_range(0, 1));
      q.hint  = 1'($urandom_range(0, 1));
      q.kind  = 2'($urandom_range(0, 3));
      drive_request(q);
    end
  endtask

  initial begin
    pkt_spec_t s;
    int p;
    int start_bytes;
    logic [15:0] port;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets, parsed against the reset port value.
    send_stray_bytes();
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b0, 0, L3_V4, vxoh_pkg::PROTO_UDP,
                          16'd0, 1, 1'b0));
    send_packet(make_spec(2'd3, 1'b1, 0, L3_V4, vxoh_pkg::PROTO_UDP, 16'd0, 1, 1'b0));
    send_packet(make_spec(2'd1, 1'b0, 0, L3_V4, vxoh_pkg::PROTO_UDP, 16'd0, 5, 1'b0));
    send_packet(make_spec(2'd2, 1'b1, 0, L3_V6, vxoh_pkg::PROTO_UDP, 16'd0, 3, 1'b0));
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b0, 0, L3_OTHER, 8'h00, 16'd0, 20, 1'b0));
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b0, 2, L3_V4, vxoh_pkg::PROTO_UDP,
                          16'd0, 22, 1'b0));
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b0, 0, L3_V4, vxoh_pkg::PROTO_UDP,
                          vxoh_pkg::VXLAN_PORT_DEFAULT, 38, 1'b0));
    send_stray_bytes();
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b0, 1, L3_V4, vxoh_pkg::PROTO_UDP,
                          vxoh_pkg::VXLAN_PORT_DEFAULT, 60, 1'b0));
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b1, 1, L3_V6, vxoh_pkg::PROTO_UDP,
                          16'hFFFF, 70, 1'b0));
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b0, 0, L3_V6, vxoh_pkg::PROTO_UDP,
                          16'h0000, 58, 1'b0));
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b0, 0, L3_V4, 8'd6,
                          vxoh_pkg::VXLAN_PORT_DEFAULT, 40, 1'b0));
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b1, 0, L3_V4, vxoh_pkg::PROTO_UDP,
                          16'd0, 30, 1'b0));
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b0, 0, L3_V4, vxoh_pkg::PROTO_UDP,
                          16'd0, 20, 1'b1));
    send_packet(make_spec(vxoh_pkg::KIND_VXLAN, 1'b0, 0, L3_V4, vxoh_pkg::PROTO_UDP,
                          vxoh_pkg::VXLAN_PORT_DEFAULT, 37, 1'b0));

    // Long receiver hold-off while short verdict-producing packets keep coming.
    drain();
    hold_off_req = 1'b1;
    steady = 1'b1;
    repeat (40) send_packet(make_spec(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)),
                                      0, L3_V4, vxoh_pkg::PROTO_UDP, 16'd0, 1, 1'b0));
    steady = 1'b0;

    // Random phases, each under its own UDP port setting.
    for (p = 0; p < 5; p++) begin
      case (p)
        0: port = 16'h0000;
        1: port = 16'hFFFF;
        3: port = vxoh_pkg::VXLAN_PORT_DEFAULT;
        default: port = 16'($urandom_range(0, 65535));
      endcase
      write_udp_port(port);
      start_bytes = bytes_sent;
      while (bytes_sent - start_bytes < PHASE_BYTES) begin
        steady = ($urandom_range(0, 5) == 0);
        s = random_packet();
        send_packet(s);
        if (!s.open_end && $urandom_range(0, 9) == 0) send_stray_bytes();
      end
      steady = 1'b0;
    end

    drain();
    if (sb.errors == 0 && sb.pending_verdicts.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
